FILE: rtl/fwt3_pkg.sv
// Shared constants, types and index helpers for the 3-D Fenwick tree range-sum unit.
package fwt3_pkg;

  localparam int IDX_W  = 4;
  localparam int ADDR_W = 3 * IDX_W;
  localparam int DATA_W = 32;
  localparam int CELLS  = 1 << ADDR_W;

  localparam logic [IDX_W-1:0] SIDE = 4'd15;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;

  // Bundle of write-port controls for the cell store.
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } ram_wr_t;

  // Side in use, with zero treated as one and anything above SIDE as SIDE.
  function automatic idx_t fwt3_eff_side(input idx_t s);
    idx_t r;
    if (s == '0) begin
      r = idx_t'(1);
    end else if (s > SIDE) begin
      r = SIDE;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Coordinates at or above the side are pulled back to side minus one.
  function automatic idx_t fwt3_clamp(input idx_t v, input idx_t s);
    return (v >= s) ? (s - idx_t'(1)) : v;
  endfunction

  // Upward step of an update walk, one bit wider so that it can pass the side.
  function automatic logic [IDX_W:0] fwt3_up_next(input idx_t i);
    logic [IDX_W:0] w;
    w = {1'b0, i};
    return w | (w + (IDX_W+1)'(1));
  endfunction

  // True when a prefix walk has another index below this one.
  function automatic logic fwt3_dn_more(input idx_t i);
    return (i & (i + idx_t'(1))) != '0;
  endfunction

  // Downward step of a prefix walk; only meaningful when fwt3_dn_more is true.
  function automatic idx_t fwt3_dn_next(input idx_t i);
    return (i & (i + idx_t'(1))) - idx_t'(1);
  endfunction

endpackage

FILE: rtl/fwt3_cell_ram.sv
// Single-port-write, single-port-read synchronous store of Fenwick tree cells.
module fwt3_cell_ram
  import fwt3_pkg::*;
(
  input  logic    clk,
  input  ram_wr_t wr,
  input  addr_t   rd_addr,
  output word_t   rd_data
);

  word_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data is registered, so it arrives in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/fenwick_tree_3d_range_sum_unit.sv
// Top level of the 3-D Fenwick tree range-sum unit: sequencer, walks and output register.
//
// This block keeps a three-dimensional binary indexed tree of 32-bit wrapping cells in one
// 4096-word synchronous memory addressed by {i, j, k}. After reset it writes zero to every
// cell and stalls requests meanwhile; configuration writes are taken at any time. An update
// request (command 0) adds delta along the upward Fenwick walk of its point; each cell
// visited costs a read and a write. A query request (command 1) runs the eight
// inclusion-exclusion prefix walks back to back: a load state per corner, one memory read
// per cycle in each walk, then drain and publish states; the single memory read port sets
// that rate. Only one request is worked on at a time, but the result sits in an output
// register, so a new request is accepted while an earlier box sum still waits to be taken.
// Coordinates at or above the side in use are clamped to side minus one, a side of zero is
// taken as one, and an inverted box simply yields what the signed formula gives.
module fenwick_tree_3d_range_sum_unit
  import fwt3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  x_low,
  input  logic [3:0]  y_low,
  input  logic [3:0]  z_low,
  input  logic [3:0]  x_high,
  input  logic [3:0]  y_high,
  input  logic [3:0]  z_high,
  input  logic signed [31:0] delta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] box_sum
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_RD,
    ST_U_WR,
    ST_Q_LOAD,
    ST_Q_WALK,
    ST_Q_DRAIN,
    ST_Q_DONE
  } state_t;

  state_t  state;
  idx_t    side;
  addr_t   clr_addr;
  idx_t    lo_x, lo_y, lo_z;
  idx_t    hi_x, hi_y, hi_z;
  idx_t    i, j, k;
  logic [2:0] corner;
  word_t   delta_q;
  word_t   acc;
  logic    acc_en;
  logic    acc_neg;

  ram_wr_t ram_wr;
  addr_t   rd_addr;
  word_t   rd_data;

  idx_t    s_eff;
  logic    in_take;
  idx_t    cx, cy, cz;
  logic    corner_empty;
  idx_t    j_start, k_start;
  idx_t    i_next, j_next, k_next;
  logic    walk_end;
  logic [IDX_W:0] i_up, j_up, k_up;

  assign s_eff    = fwt3_eff_side(side);
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Start indices of the current corner: a set bit picks the upper corner coordinate.
  assign cx = corner[2] ? hi_x : lo_x;
  assign cy = corner[1] ? hi_y : lo_y;
  assign cz = corner[0] ? hi_z : lo_z;
  assign corner_empty = (cx == '0) || (cy == '0) || (cz == '0);

  assign i_up = fwt3_up_next(i);
  assign j_up = fwt3_up_next(j);
  assign k_up = fwt3_up_next(k);

  // Inner indices restart from the walk's own start when an outer index steps.
  always_comb begin
    if (state == ST_U_WR) begin
      j_start = lo_y + idx_t'(1);
      k_start = lo_z + idx_t'(1);
    end else begin
      j_start = cy;
      k_start = cz;
    end
  end

  // Odometer-style stepping of the nested walk; k is the innermost index.
  always_comb begin
    i_next   = i;
    j_next   = j;
    k_next   = k;
    walk_end = 1'b0;
    if (state == ST_U_WR) begin
      if (k_up <= {1'b0, s_eff}) begin
        k_next = k_up[IDX_W-1:0];
      end else if (j_up <= {1'b0, s_eff}) begin
        k_next = k_start;
        j_next = j_up[IDX_W-1:0];
      end else if (i_up <= {1'b0, s_eff}) begin
        k_next = k_start;
        j_next = j_start;
        i_next = i_up[IDX_W-1:0];
      end else begin
        walk_end = 1'b1;
      end
    end else begin
      if (fwt3_dn_more(k)) begin
        k_next = fwt3_dn_next(k);
      end else if (fwt3_dn_more(j)) begin
        k_next = k_start;
        j_next = fwt3_dn_next(j);
      end else if (fwt3_dn_more(i)) begin
        k_next = k_start;
        j_next = j_start;
        i_next = fwt3_dn_next(i);
      end else begin
        walk_end = 1'b1;
      end
    end
  end

  assign rd_addr = {i, j, k};

  always_comb begin
    ram_wr.en   = 1'b0;
    ram_wr.addr = {i, j, k};
    ram_wr.data = rd_data + delta_q;
    case (state)
      ST_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = clr_addr;
        ram_wr.data = '0;
      end
      ST_U_WR: begin
        ram_wr.en = 1'b1;
      end
      default: begin
        ram_wr.en = 1'b0;
      end
    endcase
  end

  fwt3_cell_ram u_cell_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      side      <= SIDE;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      acc_en    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        side <= cfg_wr_data;
      end
      // A query that publishes in this cycle drives out_valid itself.
      if (out_valid && !out_stall && (state != ST_Q_DONE)) begin
        out_valid <= 1'b0;
      end

      // Read data of a walk step lands in the cycle after its address was issued.
      acc_en  <= (state == ST_Q_WALK);
      acc_neg <= ^(~corner);
      if (acc_en) begin
        acc <= acc_neg ? (acc - rd_data) : (acc + rd_data);
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + addr_t'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            lo_x    <= fwt3_clamp(x_low, s_eff);
            lo_y    <= fwt3_clamp(y_low, s_eff);
            lo_z    <= fwt3_clamp(z_low, s_eff);
            hi_x    <= fwt3_clamp(x_high, s_eff) + idx_t'(1);
            hi_y    <= fwt3_clamp(y_high, s_eff) + idx_t'(1);
            hi_z    <= fwt3_clamp(z_high, s_eff) + idx_t'(1);
            delta_q <= word_t'(delta);
            i       <= fwt3_clamp(x_low, s_eff) + idx_t'(1);
            j       <= fwt3_clamp(y_low, s_eff) + idx_t'(1);
            k       <= fwt3_clamp(z_low, s_eff) + idx_t'(1);
            corner  <= '0;
            acc     <= '0;
            state   <= command ? ST_Q_LOAD : ST_U_RD;
          end
        end
        ST_U_RD: begin
          state <= ST_U_WR;
        end
        ST_U_WR: begin
          i <= i_next;
          j <= j_next;
          k <= k_next;
          state <= walk_end ? ST_IDLE : ST_U_RD;
        end
        ST_Q_LOAD: begin
          i <= cx;
          j <= cy;
          k <= cz;
          if (corner_empty) begin
            corner <= corner + 3'd1;
            if (corner == 3'd7) begin
              state <= ST_Q_DRAIN;
            end
          end else begin
            state <= ST_Q_WALK;
          end
        end
        ST_Q_WALK: begin
          i <= i_next;
          j <= j_next;
          k <= k_next;
          if (walk_end) begin
            corner <= corner + 3'd1;
            state  <= (corner == 3'd7) ? ST_Q_DRAIN : ST_Q_LOAD;
          end
        end
        ST_Q_DRAIN: begin
          state <= ST_Q_DONE;
        end
        ST_Q_DONE: begin
          if (!out_valid || !out_stall) begin
            box_sum   <= acc;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A new box sum appears only when a query publishes it.
  a_out_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_Q_DONE))
    else $error("box sum published outside query completion");

  // Accumulation only follows a read issued by a prefix walk.
  a_acc_after_walk: assert property (@(posedge clk) disable iff (rst)
    acc_en |-> $past(state == ST_Q_WALK))
    else $error("accumulate without a preceding walk read");

  // The cell store is never written while a query is reading it.
  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_WALK || state == ST_Q_LOAD || state == ST_Q_DRAIN) |-> !ram_wr.en)
    else $error("cell store written during a query");

  // No request is taken while the clearing pass is still running.
  a_stall_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");
`endif

endmodule

FILE: tb/sv/tb_fenwick_tree_3d_range_sum_unit.sv
// Testbench for the 3-D Fenwick tree range-sum unit, checked against a behavioral tree model.
`timescale 1ns / 100ps
module tb_fenwick_tree_3d_range_sum_unit;
  import fwt3_pkg::*;

  // The model keeps a full 16 x 16 x 16 store, indexed like the block's memory.
  localparam int EDGE_N        = 16;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int UPDATE_SETTLE = 200;
  localparam int QUERY_SETTLE  = 600;
  localparam int PHASE_ITEMS   = 120;
  localparam int QUIET_ITEMS   = 60;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  // One request as the sender sees it, before any clamping.
  typedef struct {
    cmd_e  cmd;
    idx_t  xl;
    idx_t  yl;
    idx_t  zl;
    idx_t  xh;
    idx_t  yh;
    idx_t  zh;
    word_t delta;
  } fw_req_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [3:0]         cfg_wr_data = 4'd0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               command     = 1'b0;
  logic [3:0]         x_low       = 4'd0;
  logic [3:0]         y_low       = 4'd0;
  logic [3:0]         z_low       = 4'd0;
  logic [3:0]         x_high      = 4'd0;
  logic [3:0]         y_high      = 4'd0;
  logic [3:0]         z_high      = 4'd0;
  logic signed [31:0] delta       = 32'sd0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] box_sum;

  fenwick_tree_3d_range_sum_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .x_low       (x_low),
    .y_low       (y_low),
    .z_low       (z_low),
    .x_high      (x_high),
    .y_high      (y_high),
    .z_high      (z_high),
    .delta       (delta),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .box_sum     (box_sum)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be driven, and box sums the block still owes us.
  fw_req_t     pending_reqs[$];
  word_t       box_sums_due[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // When set, neither side inserts idle or stall cycles any more.
  logic quiet = 1'b0;

  // Shadow copy of the tree store and of the side register.
  word_t       tree_words [0:EDGE_N*EDGE_N*EDGE_N-1];
  int unsigned side_reg = 15;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A side of zero behaves as one, and nothing goes above the built-in size.
  function automatic int side_eff();
    if (side_reg == 0) return 1;
    if (side_reg > int'(SIDE)) return int'(SIDE);
    return side_reg;
  endfunction

  function automatic int clamp_to(input int v, input int s);
    return (v >= s) ? s - 1 : v;
  endfunction

  function automatic int word_at(input int i, input int j, input int k);
    return (i * EDGE_N + j) * EDGE_N + k;
  endfunction

  // Upward walk from a one-based point; every covering node takes the delta.
  function automatic void add_point(input int x, input int y, input int z, input word_t d,
                                    input int s);
    for (int i = x; i <= s; i = i | (i + 1))
      for (int j = y; j <= s; j = j | (j + 1))
        for (int k = z; k <= s; k = k | (k + 1))
          tree_words[word_at(i, j, k)] += d;
  endfunction

  // Sum over the one-based prefix box 1..x, 1..y, 1..z; a zero bound gives zero.
  function automatic word_t prefix_sum(input int x, input int y, input int z);
    word_t acc;
    acc = '0;
    for (int i = x; i > 0; i = (i & (i + 1)) - 1)
      for (int j = y; j > 0; j = (j & (j + 1)) - 1)
        for (int k = z; k > 0; k = (k & (k + 1)) - 1)
          acc += tree_words[word_at(i, j, k)];
    return acc;
  endfunction

  // Applies one accepted request to the shadow tree. A query queues its box sum,
  // formed by inclusion-exclusion over the eight corner prefixes. The lower corner
  // stays zero-based, so it names the prefix just below the box; an inverted box
  // simply runs through the same formula and wraps.
  function automatic void predict_request(input fw_req_t r);
    int    s;
    int    xl;
    int    yl;
    int    zl;
    int    xh;
    int    yh;
    int    zh;
    word_t acc;
    s  = side_eff();
    xl = clamp_to(r.xl, s);
    yl = clamp_to(r.yl, s);
    zl = clamp_to(r.zl, s);
    if (r.cmd == CMD_UPDATE) begin
      add_point(xl + 1, yl + 1, zl + 1, r.delta, s);
    end else begin
      xh  = clamp_to(r.xh, s) + 1;
      yh  = clamp_to(r.yh, s) + 1;
      zh  = clamp_to(r.zh, s) + 1;
      acc = prefix_sum(xh, yh, zh)
          - prefix_sum(xh, yh, zl) - prefix_sum(xh, yl, zh) - prefix_sum(xl, yh, zh)
          + prefix_sum(xh, yl, zl) + prefix_sum(xl, yh, zl) + prefix_sum(xl, yl, zh)
          - prefix_sum(xl, yl, zl);
      box_sums_due.push_back(acc);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  function automatic fw_req_t make_req(input cmd_e c, input int xl, input int yl, input int zl,
                                       input int xh, input int yh, input int zh,
                                       input word_t d);
    fw_req_t r;
    r.cmd   = c;
    r.xl    = idx_t'(xl);
    r.yl    = idx_t'(yl);
    r.zl    = idx_t'(zl);
    r.xh    = idx_t'(xh);
    r.yh    = idx_t'(yh);
    r.zh    = idx_t'(zh);
    r.delta = d;
    return r;
  endfunction

  // Mostly in range for the current side; now and then any 4-bit value, which
  // exercises clamping and toggles the top coordinate bit.
  function automatic idx_t pick_coord(input int s);
    if ($urandom_range(0, 9) == 0) return idx_t'($urandom_range(0, 15));
    return idx_t'($urandom_range(0, s - 1));
  endfunction

  // Box edges are usually ordered; about one in eight out-of-order pairs is left inverted.
  function automatic void pick_span(input int s, output idx_t lo, output idx_t hi);
    idx_t a;
    idx_t b;
    a = pick_coord(s);
    b = pick_coord(s);
    if (a > b && $urandom_range(0, 7) != 0) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
  endfunction

  function automatic word_t pick_delta();
    word_t d;
    case ($urandom_range(0, 3))
      0: begin
        d = $urandom;
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       d = 32'h7FFF_FFFF;
          1:       d = 32'h8000_0000;
          2:       d = 32'hFFFF_FFFF;
          default: d = 32'h0000_0001;
        endcase
      end
      default: begin
        d = word_t'($urandom_range(0, 2000)) - word_t'(1000);
      end
    endcase
    return d;
  endfunction

  function automatic fw_req_t rand_req(input int s);
    fw_req_t r;
    r.cmd = ($urandom_range(0, 1) == 0) ? CMD_UPDATE : CMD_QUERY;
    pick_span(s, r.xl, r.xh);
    pick_span(s, r.yl, r.yh);
    pick_span(s, r.zl, r.zh);
    r.delta = pick_delta();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: presents queued requests, with random idle bursts.
  // ---------------------------------------------------------------------------

  fw_req_t cur_req;
  int      idle_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(cur_req);
      end
      // A stalled request holds still; otherwise the slot is free for the next one.
      if (!(in_valid && in_stall)) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          in_valid  <= 1'b0;
        end else if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 5) != 0)) begin
          cur_req = pending_reqs.pop_front();
          command  <= cur_req.cmd;
          x_low    <= cur_req.xl;
          y_low    <= cur_req.yl;
          z_low    <= cur_req.zl;
          x_high   <= cur_req.xh;
          y_high   <= cur_req.yh;
          z_high   <= cur_req.zh;
          delta    <= cur_req.delta;
          in_valid <= 1'b1;
        end else begin
          // This cycle idles; outside the quiet phase a random idle burst follows while requests wait.
          in_valid <= 1'b0;
          if (!quiet && pending_reqs.size() != 0) begin
            idle_left <= $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stalls in random bursts and checks each box sum taken.
  // ---------------------------------------------------------------------------

  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (box_sums_due.size() == 0) begin
          $display("%0t: unexpected box_sum, expected none, actual %0d", $time, box_sum);
          mismatch_count++;
        end else if (box_sum !== box_sums_due[0]) begin
          $display("%0t: box_sum mismatch, expected %0d, actual %0d", $time,
                   $signed(box_sums_due[0]), box_sum);
          mismatch_count++;
          void'(box_sums_due.pop_front());
        end else begin
          void'(box_sums_due.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // The run ends here if the block hangs or never returns an owed box sum.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Phases
  // ---------------------------------------------------------------------------

  // Waits until every request has been taken and every box sum returned, then
  // gives a trailing update walk time to finish before the side may change.
  task automatic wait_drained();
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid || box_sums_due.size() != 0);
    repeat (UPDATE_SETTLE) @(posedge clk);
  endtask

  task automatic write_side(input logic [3:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    side_reg = v;
  endtask

  // Requests are queued at the falling edge so the driver never races the fill.
  task automatic run_random(input int count);
    @(negedge clk);
    for (int n = 0; n < count; n++) begin
      pending_reqs.push_back(rand_req(side_eff()));
    end
    wait_drained();
  endtask

  logic [3:0] phase_sides [9] = '{4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd11, 4'd14, 4'd0, 4'd0};

  initial begin
    for (int n = 0; n < EDGE_N * EDGE_N * EDGE_N; n++) begin
      tree_words[n] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset side of 15. The block clears its store first
    // and holds off requests meanwhile, so these simply wait for acceptance.
    @(negedge clk);
    pending_reqs.push_back(make_req(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(CMD_UPDATE, 14, 14, 14, 0, 0, 0, 32'h8000_0000));
    // Out-of-range point clamps onto the far corner.
    pending_reqs.push_back(make_req(CMD_UPDATE, 15, 15, 15, 15, 15, 15, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(CMD_QUERY, 0, 0, 0, 14, 14, 14, 32'h0000_0000));
    pending_reqs.push_back(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(CMD_QUERY, 14, 14, 14, 15, 15, 15, 32'h8000_0000));
    pending_reqs.push_back(make_req(CMD_UPDATE, 3, 7, 11, 9, 2, 6, 32'd12345));
    pending_reqs.push_back(make_req(CMD_UPDATE, 5, 0, 9, 0, 0, 0, 32'h0000_0000));
    // Fully inverted box, then a box inverted on one axis only.
    pending_reqs.push_back(make_req(CMD_QUERY, 10, 10, 10, 2, 3, 4, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(CMD_QUERY, 0, 14, 5, 14, 0, 5, 32'h0000_0000));
    pending_reqs.push_back(make_req(CMD_QUERY, 15, 15, 15, 15, 15, 15, 32'h0000_0000));
    pending_reqs.push_back(make_req(CMD_QUERY, 0, 0, 0, 15, 15, 15, 32'h0000_0000));
    pending_reqs.push_back(make_req(CMD_QUERY, 3, 7, 11, 3, 7, 11, 32'h0000_0000));
    wait_drained();

    // A side of zero acts as one. Existing data stays in the store, and the
    // walks now only see the corner node.
    write_side(4'd0);
    @(negedge clk);
    pending_reqs.push_back(make_req(CMD_QUERY, 0, 0, 0, 15, 15, 15, 32'h0000_0000));
    pending_reqs.push_back(make_req(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 32'd100));
    pending_reqs.push_back(make_req(CMD_UPDATE, 9, 9, 9, 0, 0, 0, 32'd7));
    pending_reqs.push_back(make_req(CMD_QUERY, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
    pending_reqs.push_back(make_req(CMD_QUERY, 3, 3, 3, 0, 0, 0, 32'h0000_0000));
    wait_drained();

    // Random phases over a range of sides; the last two draw any register value.
    for (int p = 0; p < 9; p++) begin
      if (p >= 7) begin
        phase_sides[p] = 4'($urandom_range(0, 15));
      end
      write_side(phase_sides[p]);
      run_random(PHASE_ITEMS);
    end

    // Final phase at the full side with both channels running flat out.
    @(posedge clk);
    quiet <= 1'b1;
    write_side(4'd15);
    run_random(QUIET_ITEMS);

    repeat (QUERY_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
